/* rtl/core/tptc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package tptc_pkg;
   localparam logic [1:0] FUNC_EDGE_FIRST  = 2'd0;
   localparam logic [1:0] FUNC_EDGE_SECOND = 2'd1;
   localparam logic [1:0] FUNC_COMPUTE     = 2'd2;

   typedef struct packed {
      logic [1:0] func;
      logic [5:0] node_a;
      logic [5:0] node_b;
   } req_type;

   typedef struct packed {
      logic [5:0] node_index;
      logic [7:0] target_count;
      logic       last;
   } rsp_type;
endpackage
`default_nettype wire

/* rtl/core/tree_parity_target_counter.sv */
// An edge request is stored while idle and busy stays low, so edge requests can follow.
// A compute request walks each tree breadth first from node 0: a set-up state, then for every
// node reached the pop, load, scan and next states, where the scan runs over that tree's edges.
// Then each node of the first tree is emitted; its result is registered in pend, then in the output.
// The receiver cannot stall: each result is shown for exactly one cycle, the last in the first idle cycle.
// Reset is synchronous and active high; it clears the totals, tallies and visited marks.
`timescale 1ns / 1ps
`default_nettype none
module tree_parity_target_counter #(
   parameter int MAX_NODES = 64
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   output logic                  busy,
   input  tptc_pkg::req_type     req_data,
   output logic                  rsp_valid,
   output tptc_pkg::rsp_type     rsp_data
);
   import tptc_pkg::*;

   localparam int EW = $clog2(MAX_NODES);
   localparam int CW = $clog2(MAX_NODES + 1);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b00000001,
      ST_INIT  = 8'b00000010,
      ST_POP   = 8'b00000100,
      ST_LOAD  = 8'b00001000,
      ST_SCAN  = 8'b00010000,
      ST_NEXT  = 8'b00100000,
      ST_EMIT  = 8'b01000000,
      ST_FLUSH = 8'b10000000
   } state_type;

   logic [11:0]   edge_mem [2][MAX_NODES];
   logic [6:0]    queue_mem [MAX_NODES];
   logic          odd_mem [MAX_NODES];
   logic [11:0]   edge_rd_ff;
   logic [6:0]    queue_rd_ff;
   logic          odd_rd_ff;

   state_type     state_ff, state_in;
   logic [EW-1:0] total_ff [2];
   logic          tree_ff;
   logic [EW:0]   head_ff, tail_ff;
   logic [EW-1:0] scan_ff, emit_ff;
   logic          check_ff;
   logic [5:0]    cur_ff;
   logic          cur_odd_ff;
   logic [MAX_NODES-1:0] vis_ff [2];
   logic [CW-1:0] tally_ff [4];
   logic          pend_ff, pend_vis_ff, pend_last_ff;
   logic [EW-1:0] pend_idx_ff;

   logic          accept;
   logic          store_first, store_second;
   logic [EW-1:0] cur_total;
   logic [5:0]    edge_a, edge_b, other;
   logic          hit, discover;
   logic [CW-1:0] own_tally, best_tally;

   assign busy = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign cur_total = total_ff[tree_ff];
   assign store_first = accept && req_data.func == FUNC_EDGE_FIRST &&
                        32'(total_ff[0]) < MAX_NODES - 1;
   assign store_second = accept && req_data.func == FUNC_EDGE_SECOND &&
                         32'(total_ff[1]) < MAX_NODES - 1;
   assign best_tally = (tally_ff[2] > tally_ff[3]) ? tally_ff[2] : tally_ff[3];
   assign own_tally = (pend_vis_ff && !odd_rd_ff) ? tally_ff[0] : tally_ff[1];

   always_comb begin
      edge_a = edge_rd_ff[11:6];
      edge_b = edge_rd_ff[5:0];
      hit = 1'b0;
      other = edge_b;
      if (check_ff && 7'(edge_a) <= 7'(cur_total) && 7'(edge_b) <= 7'(cur_total)) begin
         if (edge_a == cur_ff) begin
            hit = 1'b1;
            other = edge_b;
         end else if (edge_b == cur_ff) begin
            hit = 1'b1;
            other = edge_a;
         end
      end
      discover = hit && !vis_ff[tree_ff][other[EW-1:0]];
   end

   always_ff @(posedge clock) begin
      edge_rd_ff <= edge_mem[tree_ff][scan_ff];
      queue_rd_ff <= queue_mem[head_ff[EW-1:0]];
      odd_rd_ff <= odd_mem[emit_ff];
      if (store_first)
         edge_mem[0][total_ff[0]] <= {req_data.node_a, req_data.node_b};
      if (store_second)
         edge_mem[1][total_ff[1]] <= {req_data.node_a, req_data.node_b};
      if (state_ff == ST_INIT)
         queue_mem[0] <= '0;
      else if (state_ff == ST_SCAN && discover)
         queue_mem[tail_ff[EW-1:0]] <= {!cur_odd_ff, other};
      if (state_ff == ST_INIT && !tree_ff)
         odd_mem[0] <= 1'b0;
      else if (state_ff == ST_SCAN && discover && !tree_ff)
         odd_mem[other[EW-1:0]] <= !cur_odd_ff;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (accept && req_data.func == FUNC_COMPUTE) state_in = ST_INIT;
         ST_INIT:  state_in = ST_POP;
         ST_POP:   state_in = ST_LOAD;
         ST_LOAD:  state_in = ST_SCAN;
         ST_SCAN:  if (scan_ff == cur_total) state_in = ST_NEXT;
         ST_NEXT: begin
            if (head_ff != tail_ff) state_in = ST_POP;
            else if (!tree_ff) state_in = ST_INIT;
            else state_in = ST_EMIT;
         end
         ST_EMIT:  if (emit_ff == total_ff[0]) state_in = ST_FLUSH;
         ST_FLUSH: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         total_ff[0] <= '0;
         total_ff[1] <= '0;
         tree_ff <= 1'b0;
         head_ff <= '0;
         tail_ff <= '0;
         scan_ff <= '0;
         emit_ff <= '0;
         check_ff <= 1'b0;
         vis_ff[0] <= '0;
         vis_ff[1] <= '0;
         for (int k = 0; k < 4; k++) tally_ff[k] <= '0;
         pend_ff <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         check_ff <= (state_ff == ST_SCAN) && (scan_ff != cur_total);
         pend_ff <= (state_ff == ST_EMIT);
         pend_idx_ff <= emit_ff;
         pend_vis_ff <= vis_ff[0][emit_ff];
         pend_last_ff <= (emit_ff == total_ff[0]);
         rsp_valid <= pend_ff;
         if (pend_ff) begin
            rsp_data.node_index <= 6'(pend_idx_ff);
            rsp_data.target_count <= 8'(own_tally) + 8'(best_tally);
            rsp_data.last <= pend_last_ff;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (store_first) total_ff[0] <= total_ff[0] + 1'b1;
               if (store_second) total_ff[1] <= total_ff[1] + 1'b1;
               tree_ff <= 1'b0;
            end
            ST_INIT: begin
               vis_ff[tree_ff] <= {{(MAX_NODES - 1){1'b0}}, 1'b1};
               head_ff <= '0;
               tail_ff <= {{EW{1'b0}}, 1'b1};
            end
            ST_POP: begin
            end
            ST_LOAD: begin
               cur_ff <= queue_rd_ff[5:0];
               cur_odd_ff <= queue_rd_ff[6];
               tally_ff[{tree_ff, queue_rd_ff[6]}] <= tally_ff[{tree_ff, queue_rd_ff[6]}] + 1'b1;
               head_ff <= head_ff + 1'b1;
               scan_ff <= '0;
            end
            ST_SCAN: begin
               if (scan_ff != cur_total) scan_ff <= scan_ff + 1'b1;
               if (discover) begin
                  vis_ff[tree_ff][other[EW-1:0]] <= 1'b1;
                  tail_ff <= tail_ff + 1'b1;
               end
            end
            ST_NEXT: begin
               if (head_ff == tail_ff && !tree_ff) tree_ff <= 1'b1;
               emit_ff <= '0;
            end
            ST_EMIT: emit_ff <= emit_ff + 1'b1;
            ST_FLUSH: begin
               total_ff[0] <= '0;
               total_ff[1] <= '0;
               for (int k = 0; k < 4; k++) tally_ff[k] <= '0;
               vis_ff[0] <= '0;
               vis_ff[1] <= '0;
            end
            default: begin
            end
         endcase
      end
   end

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("The state register is not one-hot.");
   a_queue_order: assert property (@(posedge clock) disable iff (reset)
      head_ff <= tail_ff) else $error("The queue head has passed its tail.");
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      tail_ff <= (EW + 1)'(MAX_NODES)) else $error("The queue has overflowed.");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last) |-> !busy) else $error("The last result came while busy.");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.target_count <= 8'(2 * MAX_NODES))
      else $error("The target count is out of range.");
endmodule
`default_nettype wire
